FILE: src/stack_expression_evaluator_defines.svh
// Assertion macros used by the stack expression evaluator datapath.
`ifndef STACK_EXPRESSION_EVALUATOR_DEFINES_SVH
`define STACK_EXPRESSION_EVALUATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked check, switched off while reset is asserted
`define SEE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset
`define SEE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SEE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SEE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: src/see_pkg.sv
// Shared types and constants of the stack expression evaluator.
package see_pkg;

	// Default stack depth
	localparam int STACK_DEPTH_DEF = 64;

	// Divider iterations, one quotient bit each
	localparam int DIV_STEPS = 32;

	// Configuration register indexes
	localparam int REG_NOTATION = 0;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	// Value of a pop from an empty stack
	localparam logic [31:0] EMPTY_POP = 32'hFFFF_FFFF;

	// Controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP_A,
		ST_WAIT_A,
		ST_POP_B,
		ST_WAIT_B,
		ST_EXEC,
		ST_DIV,
		ST_DIV_FIX,
		ST_PUSH,
		ST_FIN,
		ST_FINAL_POP,
		ST_FINAL_WAIT,
		ST_EMIT
	} state_t;

	// Datapath commands
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_LOAD_DIGIT,
		CMD_POP,
		CMD_ALU,
		CMD_DIV_INIT,
		CMD_DIV_STEP,
		CMD_DIV_FIX,
		CMD_DIVZ,
		CMD_PUSH,
		CMD_EMIT
	} dp_cmd_t;

	// Controller to datapath
	typedef struct packed {
		dp_cmd_t cmd;
		logic    slot;   // operand register a pop lands in
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_nul;
		logic is_op;
		logic is_div;
		logic prefix;
		logic cnt_ge2;
		logic last;
		logic div_zero;
		logic div_done;
		logic out_busy;
	} dp_stat_t;

endpackage

FILE: src/stack_expression_evaluator.sv
// Stack expression evaluator: top level with stream ports and register port.
//
// Takes one ASCII character per input word on s_* (tdata[7:0] = symbol,
// tlast marks the final character). Digits push 0..9; + - * / pop two
// entries and push the 32-bit wrapping result. notation (register 0 at
// address 0) selects postfix (0) or prefix fed last to first (1).
// On a word with tlast the top is popped and sent as one word on m_*:
// tdata = value, tuser = {divide_by_zero, overflow_seen, underflow_seen}.
// One character at a time: s_tready is high only between characters.
// Per character: NUL or an ignored character ends after decode; a digit is
// pushed; a dropped character pops two entries and pushes nothing; + - * and
// divide by zero pop two and push; divide runs the 32-step restoring divider
// first. The final pop on tlast reads the top through the registered RAM port.
// The result sits in an output register, so the next expression may start
// while it waits; a second result waits until m_tready takes the first.
// Reset empties the stack, clears flags and notation; no clearing pass.
module stack_expression_evaluator #(
	parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input characters
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        s_tlast,
	// results
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] value
	output logic [2:0]  m_tuser,   // [0] underflow_seen [1] overflow_seen [2] divide_by_zero
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	see_pkg::ctrl_cmd_t cmd;
	see_pkg::dp_stat_t  stat;
	logic               cfg_we;
	logic               notation;
	logic               sel_notation;

	// register decode
	assign sel_notation = (paddr == 2'(see_pkg::REG_NOTATION * 4));
	assign pready       = 1'b1;
	assign cfg_we       = psel && penable && pwrite && pready && sel_notation;
	assign prdata       = sel_notation ? {31'd0, notation} : '0;

	see_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	see_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.in_symbol    (s_tdata),
		.in_last      (s_tlast),
		.cfg_we       (cfg_we),
		.cfg_notation (pwdata[0]),
		.notation     (notation),
		.out_ready    (m_tready),
		.out_valid    (m_tvalid),
		.out_value    (m_tdata),
		.out_flags    (m_tuser)
	);

endmodule

FILE: src/see_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module see_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: src/see_ctrl.sv
// Sequencing state machine of the stack expression evaluator.
module see_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  see_pkg::dp_stat_t     stat,
	output see_pkg::ctrl_cmd_t    cmd
);

	see_pkg::state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= see_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			see_pkg::ST_IDLE: begin
				if (in_valid) state_d = see_pkg::ST_DECODE;
			end
			see_pkg::ST_DECODE: begin
				if (stat.is_digit) begin
					state_d = see_pkg::ST_PUSH;
				end else if (stat.is_nul) begin
					state_d = see_pkg::ST_FIN;
				end else if (stat.prefix) begin
					// prefix: only an operator with two operands does anything
					state_d = (stat.is_op && stat.cnt_ge2) ? see_pkg::ST_POP_A : see_pkg::ST_FIN;
				end else begin
					state_d = see_pkg::ST_POP_A;
				end
			end
			see_pkg::ST_POP_A:  state_d = see_pkg::ST_WAIT_A;
			see_pkg::ST_WAIT_A: state_d = see_pkg::ST_POP_B;
			see_pkg::ST_POP_B:  state_d = see_pkg::ST_WAIT_B;
			see_pkg::ST_WAIT_B: state_d = see_pkg::ST_EXEC;
			see_pkg::ST_EXEC: begin
				if (!stat.is_op) begin
					state_d = see_pkg::ST_FIN;
				end else if (stat.is_div && !stat.div_zero) begin
					state_d = see_pkg::ST_DIV;
				end else begin
					state_d = see_pkg::ST_PUSH;
				end
			end
			see_pkg::ST_DIV: begin
				if (stat.div_done) state_d = see_pkg::ST_DIV_FIX;
			end
			see_pkg::ST_DIV_FIX: state_d = see_pkg::ST_PUSH;
			see_pkg::ST_PUSH:    state_d = see_pkg::ST_FIN;
			see_pkg::ST_FIN: begin
				state_d = stat.last ? see_pkg::ST_FINAL_POP : see_pkg::ST_IDLE;
			end
			see_pkg::ST_FINAL_POP:  state_d = see_pkg::ST_FINAL_WAIT;
			see_pkg::ST_FINAL_WAIT: state_d = see_pkg::ST_EMIT;
			see_pkg::ST_EMIT: begin
				if (!stat.out_busy) state_d = see_pkg::ST_IDLE;
			end
			default: state_d = see_pkg::ST_IDLE;
		endcase
	end

	// command outputs
	always_comb begin
		in_ready = 1'b0;
		cmd.cmd  = see_pkg::CMD_NONE;
		cmd.slot = 1'b0;
		case (state_q)
			see_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.cmd = see_pkg::CMD_LOAD;
			end
			see_pkg::ST_DECODE: begin
				if (stat.is_digit) cmd.cmd = see_pkg::CMD_LOAD_DIGIT;
			end
			see_pkg::ST_POP_A: begin
				cmd.cmd = see_pkg::CMD_POP;
			end
			see_pkg::ST_POP_B: begin
				cmd.cmd  = see_pkg::CMD_POP;
				cmd.slot = 1'b1;
			end
			see_pkg::ST_EXEC: begin
				if (stat.is_op) begin
					if (!stat.is_div) begin
						cmd.cmd = see_pkg::CMD_ALU;
					end else if (stat.div_zero) begin
						cmd.cmd = see_pkg::CMD_DIVZ;
					end else begin
						cmd.cmd = see_pkg::CMD_DIV_INIT;
					end
				end
			end
			see_pkg::ST_DIV:       cmd.cmd = see_pkg::CMD_DIV_STEP;
			see_pkg::ST_DIV_FIX:   cmd.cmd = see_pkg::CMD_DIV_FIX;
			see_pkg::ST_PUSH:      cmd.cmd = see_pkg::CMD_PUSH;
			see_pkg::ST_FINAL_POP: cmd.cmd = see_pkg::CMD_POP;
			see_pkg::ST_EMIT: begin
				if (!stat.out_busy) cmd.cmd = see_pkg::CMD_EMIT;
			end
			default: cmd.cmd = see_pkg::CMD_NONE;
		endcase
	end

endmodule

FILE: src/see_dp.sv
// Datapath: value stack, operand registers, ALU, divider, flags, output word.
`include "stack_expression_evaluator_defines.svh"

module see_dp #(
	parameter int STACK_DEPTH = see_pkg::STACK_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  see_pkg::ctrl_cmd_t cmd,
	output see_pkg::dp_stat_t  stat,
	input  logic [7:0]         in_symbol,
	input  logic               in_last,
	input  logic               cfg_we,
	input  logic               cfg_notation,
	output logic               notation,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [31:0]        out_value,
	output logic [2:0]         out_flags
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	// control state
	logic          notation_q;
	logic [CW-1:0] cnt_q;
	logic          uflow_q, oflow_q, divz_q;
	logic          rd_pend_q;
	logic          out_valid_q;
	logic [4:0]    step_q;

	// payload
	logic [7:0]  sym_q;
	logic        last_q;
	logic        slot_q;
	logic [31:0] pop0_q, pop1_q;
	logic [31:0] res_q;
	logic [31:0] quo_q, rem_q, dsr_q;
	logic        neg_q;
	logic [31:0] out_value_q;
	logic [2:0]  out_flags_q;

	logic [CW-1:0] cnt_dec;
	logic          empty, full;
	logic [31:0]   opl, opr, ram_rdata;
	logic          ram_we, ram_re;
	logic [32:0]   rem_sh;
	logic [32:0]   rem_sub;
	logic          is_plus, is_minus, is_star, is_slash;

	assign cnt_dec = cnt_q - CW'(1);
	assign empty   = (cnt_q == '0);
	assign full    = (cnt_q == CW'(STACK_DEPTH));

	// symbol decode
	assign is_plus  = (sym_q == see_pkg::CH_PLUS);
	assign is_minus = (sym_q == see_pkg::CH_MINUS);
	assign is_star  = (sym_q == see_pkg::CH_STAR);
	assign is_slash = (sym_q == see_pkg::CH_SLASH);

	// operand order: postfix is below op top, prefix is top op below
	assign opl = notation_q ? pop0_q : pop1_q;
	assign opr = notation_q ? pop1_q : pop0_q;

	// one restoring division step
	assign rem_sh  = {1'b0, rem_q[30:0], quo_q[31]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	// status to controller
	always_comb begin
		stat.is_digit = (sym_q >= see_pkg::CH_ZERO) && (sym_q <= see_pkg::CH_NINE);
		stat.is_nul   = (sym_q == see_pkg::CH_NUL);
		stat.is_op    = is_plus || is_minus || is_star || is_slash;
		stat.is_div   = is_slash;
		stat.prefix   = notation_q;
		stat.cnt_ge2  = (cnt_q >= CW'(2));
		stat.last     = last_q;
		stat.div_zero = (opr == '0);
		stat.div_done = (step_q == 5'(see_pkg::DIV_STEPS - 1));
		stat.out_busy = out_valid_q && !out_ready;
	end

	// stack memory
	assign ram_we = (cmd.cmd == see_pkg::CMD_PUSH) && !full;
	assign ram_re = (cmd.cmd == see_pkg::CMD_POP) && !empty;

	see_ram #(
		.WIDTH (32),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (res_q),
		.re    (ram_re),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (ram_rdata)
	);

	// stack count, flags, config and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			notation_q  <= 1'b0;
			cnt_q       <= '0;
			uflow_q     <= 1'b0;
			oflow_q     <= 1'b0;
			divz_q      <= 1'b0;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (cfg_we) notation_q <= cfg_notation;
			rd_pend_q <= ram_re;
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (cmd.cmd)
				see_pkg::CMD_POP: begin
					if (empty) uflow_q <= 1'b1;
					else cnt_q <= cnt_dec;
				end
				see_pkg::CMD_PUSH: begin
					if (full) oflow_q <= 1'b1;
					else cnt_q <= cnt_q + CW'(1);
				end
				see_pkg::CMD_DIVZ: divz_q <= 1'b1;
				see_pkg::CMD_DIV_INIT: step_q <= '0;
				see_pkg::CMD_DIV_STEP: step_q <= step_q + 5'd1;
				see_pkg::CMD_EMIT: begin
					out_valid_q <= 1'b1;
					cnt_q       <= '0;
					uflow_q     <= 1'b0;
					oflow_q     <= 1'b0;
					divz_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// operand, result and divider registers
	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			if (slot_q) pop1_q <= ram_rdata;
			else pop0_q <= ram_rdata;
		end
		case (cmd.cmd)
			see_pkg::CMD_LOAD: begin
				sym_q  <= in_symbol;
				last_q <= in_last;
			end
			see_pkg::CMD_LOAD_DIGIT: begin
				res_q <= {24'd0, 8'(sym_q - see_pkg::CH_ZERO)};
			end
			see_pkg::CMD_POP: begin
				slot_q <= cmd.slot;
				if (empty) begin
					if (cmd.slot) pop1_q <= see_pkg::EMPTY_POP;
					else pop0_q <= see_pkg::EMPTY_POP;
				end
			end
			see_pkg::CMD_ALU: begin
				if (is_plus) res_q <= opl + opr;
				else if (is_minus) res_q <= opl - opr;
				else res_q <= opl * opr;
			end
			see_pkg::CMD_DIV_INIT: begin
				quo_q <= opl[31] ? (32'd0 - opl) : opl;
				dsr_q <= opr[31] ? (32'd0 - opr) : opr;
				rem_q <= '0;
				neg_q <= opl[31] ^ opr[31];
			end
			see_pkg::CMD_DIV_STEP: begin
				if (!rem_sub[32]) begin
					rem_q <= rem_sub[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= rem_sh[31:0];
					quo_q <= {quo_q[30:0], 1'b0};
				end
			end
			see_pkg::CMD_DIV_FIX: res_q <= neg_q ? (32'd0 - quo_q) : quo_q;
			see_pkg::CMD_DIVZ:    res_q <= '0;
			see_pkg::CMD_EMIT: begin
				out_value_q <= pop0_q;
				out_flags_q <= {divz_q, oflow_q, uflow_q};
			end
			default: ;
		endcase
	end

	assign notation  = notation_q;
	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_flags = out_flags_q;

	// checks
	`SEE_ASSERT_ALWAYS(a_cnt_bound, clk, !arst_n || cnt_q <= CW'(STACK_DEPTH), "stack count above depth")
	`SEE_ASSERT(a_emit_free, clk, arst_n, cmd.cmd == see_pkg::CMD_EMIT |-> !(out_valid_q && !out_ready), "emit over a held word")
	`SEE_ASSERT(a_emit_clear, clk, arst_n, cmd.cmd == see_pkg::CMD_EMIT |=> cnt_q == '0 && !uflow_q, "stack not cleared after emit")
	`SEE_ASSERT(a_rd_after_pop, clk, arst_n, rd_pend_q |-> $past(cmd.cmd) == see_pkg::CMD_POP, "stack read without a pop")

endmodule
